/* hw/rtl/mqd_pkg.sv */
package mqd_pkg;

	localparam int NUM_CONTEXTS     = 19;
	localparam int BYTE_QUEUE_DEPTH = 16;
	localparam int QE_STATES        = 47;

	localparam int CTX_AW   = $clog2(NUM_CONTEXTS);
	localparam int QUEUE_AW = $clog2(BYTE_QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(BYTE_QUEUE_DEPTH + 1);

	localparam int OP_W  = 2;
	localparam int BYTE_W = 8;
	localparam int CX_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
	localparam logic [OP_W-1:0] OP_START  = 2'd1;
	localparam logic [OP_W-1:0] OP_DECODE = 2'd2;
	localparam logic [OP_W-1:0] OP_RESET  = 2'd3;

	localparam logic [15:0] INTERVAL_INIT = 16'h8000;
	localparam logic [31:0] FEED_ONES     = 32'h0000_FF00;
	localparam logic [7:0]  BYTE_STUFF    = 8'hFF;
	localparam logic [7:0]  MARKER_LIMIT  = 8'h8F;
	localparam logic [5:0]  LAST_STATE    = 6'd46;

	typedef struct packed {
		logic [15:0] q;
		logic [5:0]  on_mps;
		logic [5:0]  on_lps;
		logic        flip;
	} qe_row_t;

	function automatic qe_row_t qe_lookup(input logic [5:0] st);
		qe_row_t r;
		case (st)
			6'd0:  r = '{16'h5601, 6'd1,  6'd1,  1'b1};
			6'd1:  r = '{16'h3401, 6'd2,  6'd6,  1'b0};
			6'd2:  r = '{16'h1801, 6'd3,  6'd9,  1'b0};
			6'd3:  r = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
			6'd4:  r = '{16'h0521, 6'd5,  6'd29, 1'b0};
			6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
			6'd6:  r = '{16'h5601, 6'd7,  6'd6,  1'b1};
			6'd7:  r = '{16'h5401, 6'd8,  6'd14, 1'b0};
			6'd8:  r = '{16'h4801, 6'd9,  6'd14, 1'b0};
			6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
			6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
			6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
			6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
			6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
			6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
			6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
			6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
			6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
			6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
			6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
			6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
			6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
			6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
			6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
			6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
			6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
			6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
			6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
			6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
			6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
			6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
			6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
			6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
			6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
			6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
			6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
			6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
			6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
			6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
			6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
			6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
			6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
			6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
			6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
			6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
			6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
			default: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
		endcase
		return r;
	endfunction

	// probability state that a context takes after a table reset
	function automatic logic [5:0] ctx_reset_state(input int idx);
		logic [5:0] s;
		case (idx)
			0:       s = 6'd4;
			17:      s = 6'd3;
			18:      s = 6'd46;
			default: s = 6'd0;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/mqd_req_if.sv */
interface mqd_req_if;
	logic                         valid;
	logic                         ready;
	logic [mqd_pkg::OP_W-1:0]     op;
	logic [mqd_pkg::BYTE_W-1:0]   byte_value;
	logic [mqd_pkg::CX_W-1:0]     context_index;

	modport source(output valid, output op, output byte_value, output context_index,
		input ready);
	modport sink(input valid, input op, input byte_value, input context_index,
		output ready);
endinterface

/* hw/rtl/mqd_rsp_if.sv */
interface mqd_rsp_if;
	logic valid;
	logic ready;
	logic decision;
	logic end_seen;

	modport source(output valid, output decision, output end_seen, input ready);
	modport sink(input valid, input decision, input end_seen, output ready);
endinterface

/* hw/rtl/mq_arithmetic_decoder_core.sv */
// channel  dir  payload                             role
// req      in   op, byte_value, context_index       operations and code bytes
// rsp      out  decision, end_seen                  one transaction per decode
//
// push and reset-contexts finish on acceptance; start runs two byte-insertion steps, S_INIT1 and S_INIT2
// decode runs S_DEC1, S_DEC2 (skipped for a context beyond the table), one S_RENORM
// step per shift (1 to 16, or none) and S_EMIT, which loads the output register
// req.ready is high only while the sequencer is idle; the output register lets
// a new transaction in while a decision waits on rsp.ready
// arst_n resets all control state and loads the context table's reset states; no clearing pass
module mq_arithmetic_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	mqd_req_if.sink    req,
	mqd_rsp_if.source  rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_INIT1  = 3'd1;
	localparam logic [2:0] S_INIT2  = 3'd2;
	localparam logic [2:0] S_DEC1   = 3'd3;
	localparam logic [2:0] S_DEC2   = 3'd4;
	localparam logic [2:0] S_RENORM = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	localparam int CTX_IDX_W = mqd_pkg::CTX_AW;

	logic [2:0]  state_q;
	logic [15:0] a_q;
	logic [31:0] c_q;
	logic [3:0]  ct_q;
	logic [7:0]  prev_q;
	logic        end_q;
	logic [3:0]  rn_cnt_q;

	logic [5:0]  ctx_st_q  [mqd_pkg::NUM_CONTEXTS];
	logic        ctx_mps_q [mqd_pkg::NUM_CONTEXTS];

	logic [7:0]                   queue_q [mqd_pkg::BYTE_QUEUE_DEPTH];
	logic [mqd_pkg::QUEUE_AW-1:0] head_q;
	logic [mqd_pkg::QUEUE_CW-1:0] count_q;

	logic [mqd_pkg::CX_W-1:0] cx_q;
	mqd_pkg::qe_row_t         row_q;
	logic                     mps_q;
	logic                     dec_q;

	logic out_valid_q;
	logic out_dec_q;
	logic out_end_q;

	logic                         accept;
	logic                         push_en;
	logic                         pop_en;
	logic [mqd_pkg::QUEUE_AW:0]   tail_sum;
	logic [mqd_pkg::QUEUE_AW-1:0] tail;
	logic [mqd_pkg::QUEUE_AW:0]   head_sum;
	logic [mqd_pkg::QUEUE_AW-1:0] head_next;
	logic                         have_byte;
	logic [7:0]                   hb;

	logic [31:0] bi_c;
	logic [3:0]  bi_ct;
	logic [7:0]  bi_prev;
	logic        bi_end;
	logic        bi_pop;

	logic [CTX_IDX_W-1:0] ctx_idx;
	logic                 cx_ok;
	logic [5:0]           st_clamped;

	logic [15:0] a_sub;
	logic        c_low;
	logic        pick_lps;
	logic        need_rn;

	logic        rn_insert;
	logic [31:0] rn_c;
	logic [3:0]  rn_ct;
	logic [15:0] rn_a;
	logic        out_free;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign have_byte = (count_q != '0);
	assign hb        = queue_q[head_q];
	assign out_free  = !out_valid_q || rsp.ready;

	assign push_en = accept && (req.op == mqd_pkg::OP_PUSH) &&
		(int'(count_q) < mqd_pkg::BYTE_QUEUE_DEPTH);

	always_comb begin
		tail_sum = {1'b0, head_q} + (mqd_pkg::QUEUE_AW + 1)'(count_q);
		if (int'(tail_sum) >= mqd_pkg::BYTE_QUEUE_DEPTH)
			tail_sum = tail_sum - (mqd_pkg::QUEUE_AW + 1)'(mqd_pkg::BYTE_QUEUE_DEPTH);
		tail = tail_sum[mqd_pkg::QUEUE_AW-1:0];
		head_sum = {1'b0, head_q} + (mqd_pkg::QUEUE_AW + 1)'(1);
		if (int'(head_sum) >= mqd_pkg::BYTE_QUEUE_DEPTH)
			head_sum = '0;
		head_next = head_sum[mqd_pkg::QUEUE_AW-1:0];
	end

	// byte insertion with stuffing, marker detection and end of data on an empty queue
	always_comb begin
		bi_c    = c_q + mqd_pkg::FEED_ONES;
		bi_ct   = 4'd8;
		bi_prev = prev_q;
		bi_end  = end_q;
		bi_pop  = 1'b0;
		if (!end_q) begin
			if (!have_byte) begin
				bi_end = 1'b1;
			end else if (prev_q == mqd_pkg::BYTE_STUFF) begin
				if (hb > mqd_pkg::MARKER_LIMIT) begin
					bi_end = 1'b1;
				end else begin
					bi_c    = c_q + {15'b0, hb, 9'b0};
					bi_ct   = 4'd7;
					bi_prev = hb;
					bi_pop  = 1'b1;
				end
			end else begin
				bi_c    = c_q + {16'b0, hb, 8'b0};
				bi_prev = hb;
				bi_pop  = 1'b1;
			end
		end
	end

	assign rn_insert = (ct_q == 4'd0);
	assign rn_c      = (rn_insert ? bi_c : c_q) << 1;
	assign rn_ct     = (rn_insert ? bi_ct : ct_q) - 4'd1;
	assign rn_a      = a_q << 1;

	always_comb begin
		pop_en = 1'b0;
		case (state_q)
			S_INIT1:  pop_en = have_byte;
			S_INIT2:  pop_en = bi_pop;
			S_RENORM: pop_en = rn_insert && bi_pop;
			default:  pop_en = 1'b0;
		endcase
	end

	assign ctx_idx    = CTX_IDX_W'(cx_q);
	assign cx_ok      = int'(cx_q) < mqd_pkg::NUM_CONTEXTS;
	assign st_clamped = (int'(ctx_st_q[ctx_idx]) >= mqd_pkg::QE_STATES) ?
		mqd_pkg::LAST_STATE : ctx_st_q[ctx_idx];

	// interval subtract and the conditional exchange
	assign a_sub    = a_q - row_q.q;
	assign c_low    = c_q[31:16] < row_q.q;
	assign pick_lps = c_low ? !(a_sub < row_q.q) : (a_sub < row_q.q);
	assign need_rn  = c_low || !a_sub[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			a_q      <= mqd_pkg::INTERVAL_INIT;
			c_q      <= '0;
			ct_q     <= '0;
			prev_q   <= '0;
			end_q    <= 1'b0;
			rn_cnt_q <= '0;
			head_q   <= '0;
			count_q  <= '0;
			for (int i = 0; i < mqd_pkg::NUM_CONTEXTS; i++) begin
				ctx_st_q[i]  <= mqd_pkg::ctx_reset_state(i);
				ctx_mps_q[i] <= 1'b0;
			end
		end else begin
			if (push_en)
				count_q <= count_q + 1'b1;
			else if (pop_en)
				count_q <= count_q - 1'b1;
			if (pop_en)
				head_q <= head_next;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							mqd_pkg::OP_START:  state_q <= S_INIT1;
							mqd_pkg::OP_DECODE: state_q <= S_DEC1;
							mqd_pkg::OP_RESET: begin
								for (int i = 0; i < mqd_pkg::NUM_CONTEXTS; i++) begin
									ctx_st_q[i]  <= mqd_pkg::ctx_reset_state(i);
									ctx_mps_q[i] <= 1'b0;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INIT1: begin
					if (have_byte) begin
						prev_q <= hb;
						c_q    <= {8'b0, hb, 16'b0};
					end else begin
						end_q  <= 1'b1;
						prev_q <= mqd_pkg::BYTE_STUFF;
						c_q    <= {8'b0, mqd_pkg::BYTE_STUFF, 16'b0};
					end
					state_q <= S_INIT2;
				end
				S_INIT2: begin
					c_q     <= bi_c << 7;
					ct_q    <= bi_ct - 4'd7;
					prev_q  <= bi_prev;
					end_q   <= bi_end;
					a_q     <= mqd_pkg::INTERVAL_INIT;
					state_q <= S_IDLE;
				end
				S_DEC1: begin
					if (cx_ok) begin
						state_q <= S_DEC2;
					end else begin
						dec_q   <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_DEC2: begin
					rn_cnt_q <= '0;
					if (c_low) begin
						a_q <= row_q.q;
					end else begin
						a_q <= a_sub;
						c_q <= c_q - {row_q.q, 16'b0};
					end
					if (need_rn) begin
						if (pick_lps) begin
							dec_q              <= !mps_q;
							ctx_mps_q[ctx_idx] <= mps_q ^ row_q.flip;
							ctx_st_q[ctx_idx]  <= row_q.on_lps;
						end else begin
							dec_q             <= mps_q;
							ctx_st_q[ctx_idx] <= row_q.on_mps;
						end
						state_q <= S_RENORM;
					end else begin
						dec_q   <= mps_q;
						state_q <= S_EMIT;
					end
				end
				S_RENORM: begin
					if (rn_insert) begin
						prev_q <= bi_prev;
						end_q  <= bi_end;
					end
					a_q      <= rn_a;
					c_q      <= rn_c;
					ct_q     <= rn_ct;
					rn_cnt_q <= rn_cnt_q + 4'd1;
					if (rn_a[15] || rn_cnt_q == 4'd15)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (push_en)
			queue_q[tail] <= req.byte_value;
		if (accept)
			cx_q <= req.context_index;
		if (state_q == S_DEC1) begin
			row_q <= mqd_pkg::qe_lookup(st_clamped);
			mps_q <= ctx_mps_q[ctx_idx];
		end
		if (state_q == S_EMIT && out_free) begin
			out_dec_q <= dec_q;
			out_end_q <= end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.decision = out_dec_q;
	assign rsp.end_seen = out_end_q;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= mqd_pkg::BYTE_QUEUE_DEPTH)
		else $error("byte queue count beyond depth");

	a_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		ct_q <= 4'd8)
		else $error("bit counter out of range");

	a_renorm_interval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RENORM |-> a_q != 16'h0000)
		else $error("renormalisation on an empty interval");

	a_decode_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.op == mqd_pkg::OP_DECODE |=> state_q == S_DEC1)
		else $error("decode transaction did not start the sequencer");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !out_free |=> state_q == S_EMIT && out_valid_q)
		else $error("decision lost while output register busy");

endmodule

/* sim/tb_mq_arithmetic_decoder_core.sv */
module tb_mq_arithmetic_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int GAP_PERCENT  = 22;

	typedef struct packed {
		logic [15:0] q;
		logic [5:0]  on_mps;
		logic [5:0]  on_lps;
		logic        flip;
	} prob_row_t;

	localparam prob_row_t [0:mqd_pkg::QE_STATES-1] PROB_TABLE = {
		{16'h5601, 6'd1,  6'd1,  1'b1}, {16'h3401, 6'd2,  6'd6,  1'b0},
		{16'h1801, 6'd3,  6'd9,  1'b0}, {16'h0AC1, 6'd4,  6'd12, 1'b0},
		{16'h0521, 6'd5,  6'd29, 1'b0}, {16'h0221, 6'd38, 6'd33, 1'b0},
		{16'h5601, 6'd7,  6'd6,  1'b1}, {16'h5401, 6'd8,  6'd14, 1'b0},
		{16'h4801, 6'd9,  6'd14, 1'b0}, {16'h3801, 6'd10, 6'd14, 1'b0},
		{16'h3001, 6'd11, 6'd17, 1'b0}, {16'h2401, 6'd12, 6'd18, 1'b0},
		{16'h1C01, 6'd13, 6'd20, 1'b0}, {16'h1601, 6'd29, 6'd21, 1'b0},
		{16'h5601, 6'd15, 6'd14, 1'b1}, {16'h5401, 6'd16, 6'd14, 1'b0},
		{16'h5101, 6'd17, 6'd15, 1'b0}, {16'h4801, 6'd18, 6'd16, 1'b0},
		{16'h3801, 6'd19, 6'd17, 1'b0}, {16'h3401, 6'd20, 6'd18, 1'b0},
		{16'h3001, 6'd21, 6'd19, 1'b0}, {16'h2801, 6'd22, 6'd19, 1'b0},
		{16'h2401, 6'd23, 6'd20, 1'b0}, {16'h2201, 6'd24, 6'd21, 1'b0},
		{16'h1C01, 6'd25, 6'd22, 1'b0}, {16'h1801, 6'd26, 6'd23, 1'b0},
		{16'h1601, 6'd27, 6'd24, 1'b0}, {16'h1401, 6'd28, 6'd25, 1'b0},
		{16'h1201, 6'd29, 6'd26, 1'b0}, {16'h1101, 6'd30, 6'd27, 1'b0},
		{16'h0AC1, 6'd31, 6'd28, 1'b0}, {16'h09C1, 6'd32, 6'd29, 1'b0},
		{16'h08A1, 6'd33, 6'd30, 1'b0}, {16'h0521, 6'd34, 6'd31, 1'b0},
		{16'h0441, 6'd35, 6'd32, 1'b0}, {16'h02A1, 6'd36, 6'd33, 1'b0},
		{16'h0221, 6'd37, 6'd34, 1'b0}, {16'h0141, 6'd38, 6'd35, 1'b0},
		{16'h0111, 6'd39, 6'd36, 1'b0}, {16'h0085, 6'd40, 6'd37, 1'b0},
		{16'h0049, 6'd41, 6'd38, 1'b0}, {16'h0025, 6'd42, 6'd39, 1'b0},
		{16'h0015, 6'd43, 6'd40, 1'b0}, {16'h0009, 6'd44, 6'd41, 1'b0},
		{16'h0005, 6'd45, 6'd42, 1'b0}, {16'h0001, 6'd45, 6'd43, 1'b0},
		{16'h5601, 6'd46, 6'd46, 1'b0}
	};

	typedef struct packed {
		logic decision;
		logic end_seen;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	mqd_req_if req();
	mqd_rsp_if rsp();

	mq_arithmetic_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// decoder state as the block should hold it
	logic [15:0] mq_a;
	logic [31:0] mq_c;
	logic [3:0]  mq_ct;
	logic [7:0]  mq_last_byte;
	logic        mq_ended;
	logic [5:0]  ctx_state [mqd_pkg::NUM_CONTEXTS];
	logic        ctx_mps [mqd_pkg::NUM_CONTEXTS];
	logic [7:0]  code_bytes [$];
	logic [7:0]  tail_byte;

	decision_t pending_decisions [$];
	int        mismatch_count;
	int        ops_sent;
	bit        no_gaps;
	bit        hold_request;

	function automatic void restore_contexts();
		foreach (ctx_state[i]) begin
			ctx_state[i] = 6'd0;
			ctx_mps[i]   = 1'b0;
		end
		ctx_state[0]  = 6'd4;
		ctx_state[17] = 6'd3;
		ctx_state[18] = mqd_pkg::LAST_STATE;
	endfunction

	// BYTEIN: stuffing after 0xff, marker or empty queue ends the data
	function automatic void insert_code_byte();
		logic [7:0] b;
		if (mq_ended || code_bytes.size() == 0 ||
				(mq_last_byte == mqd_pkg::BYTE_STUFF &&
				code_bytes[0] > mqd_pkg::MARKER_LIMIT)) begin
			mq_ended = 1'b1;
			mq_c     = mq_c + mqd_pkg::FEED_ONES;
			mq_ct    = 4'd8;
		end else begin
			b = code_bytes.pop_front();
			if (mq_last_byte == mqd_pkg::BYTE_STUFF) begin
				mq_c  = mq_c + ({24'd0, b} << 9);
				mq_ct = 4'd7;
			end else begin
				mq_c  = mq_c + ({24'd0, b} << 8);
				mq_ct = 4'd8;
			end
			mq_last_byte = b;
		end
	endfunction

	function automatic void init_decoder();
		if (code_bytes.size() != 0) begin
			mq_last_byte = code_bytes.pop_front();
		end else begin
			mq_ended     = 1'b1;
			mq_last_byte = mqd_pkg::BYTE_STUFF;
		end
		mq_c = {8'd0, mq_last_byte, 16'd0};
		insert_code_byte();
		mq_c  = mq_c << 7;
		mq_ct = mq_ct - 4'd7;
		mq_a  = mqd_pkg::INTERVAL_INIT;
	endfunction

	function automatic void renormalise();
		int shifts;
		shifts = 0;
		do begin
			if (mq_ct == 4'd0)
				insert_code_byte();
			mq_a   = mq_a << 1;
			mq_c   = mq_c << 1;
			mq_ct  = mq_ct - 4'd1;
			shifts = shifts + 1;
		end while (!mq_a[15] && shifts < 16);
	endfunction

	function automatic logic decode_decision(input int cx);
		logic [5:0] st;
		logic       mps;
		logic       d;
		logic       shift_needed;
		logic       lps_path;
		prob_row_t  row;
		st  = ctx_state[cx];
		mps = ctx_mps[cx];
		if (st >= mqd_pkg::QE_STATES)
			st = mqd_pkg::LAST_STATE;
		row  = PROB_TABLE[st];
		mq_a = mq_a - row.q;
		if (mq_c[31:16] < row.q) begin
			// conditional exchange: the smaller sub-interval goes to the lps
			lps_path     = !(mq_a < row.q);
			mq_a         = row.q;
			shift_needed = 1'b1;
		end else begin
			mq_c         = mq_c - {row.q, 16'd0};
			lps_path     = mq_a < row.q;
			shift_needed = !mq_a[15];
		end
		if (shift_needed && lps_path) begin
			d = !mps;
			if (row.flip)
				mps = !mps;
			st = row.on_lps;
		end else if (shift_needed) begin
			d  = mps;
			st = row.on_mps;
		end else begin
			d = mps;
		end
		if (shift_needed)
			renormalise();
		ctx_state[cx] = st;
		ctx_mps[cx]   = mps;
		return d;
	endfunction

	function automatic void apply_op(input logic [mqd_pkg::OP_W-1:0] op,
			input logic [mqd_pkg::BYTE_W-1:0] bv, input logic [mqd_pkg::CX_W-1:0] cx);
		decision_t want;
		case (op)
			mqd_pkg::OP_PUSH: begin
				if (code_bytes.size() < mqd_pkg::BYTE_QUEUE_DEPTH) begin
					code_bytes.push_back(bv);
					tail_byte = bv;
				end
			end
			mqd_pkg::OP_START: init_decoder();
			mqd_pkg::OP_DECODE: begin
				if (cx < mqd_pkg::NUM_CONTEXTS)
					want.decision = decode_decision(int'(cx));
				else
					want.decision = 1'b0;
				want.end_seen = mq_ended;
				pending_decisions.push_back(want);
			end
			mqd_pkg::OP_RESET: restore_contexts();
			default: ;
		endcase
	endfunction

	// next byte of a clean code stream: no marker after a stuffed 0xff
	function automatic logic [7:0] next_code_byte();
		if (tail_byte == mqd_pkg::BYTE_STUFF)
			return 8'($urandom_range(int'(mqd_pkg::MARKER_LIMIT)));
		if ($urandom_range(9) == 0)
			return mqd_pkg::BYTE_STUFF;
		return 8'($urandom_range(255));
	endfunction

	task automatic send_op(input logic [mqd_pkg::OP_W-1:0] op,
			input logic [mqd_pkg::BYTE_W-1:0] bv, input logic [mqd_pkg::CX_W-1:0] cx);
		while (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.op            <= op;
		req.byte_value    <= bv;
		req.context_index <= cx;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		apply_op(op, bv, cx);
		ops_sent = ops_sent + 1;
	endtask

	// keep enough code bytes queued that a start or a decode never runs dry
	task automatic top_up_code();
		while (code_bytes.size() < 4)
			send_op(mqd_pkg::OP_PUSH, next_code_byte(), 5'($urandom_range(31)));
	endtask

	task automatic wait_for_decisions();
		req.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_decisions.size() != 0);
	endtask

	task automatic test_directed();
		logic [7:0] opening [0:16];
		logic [4:0] probe_cx [0:4];
		opening = '{8'h00, 8'hFF, 8'h8F, 8'h12, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'hC3,
			8'h3C, 8'hA5, 8'h5A, 8'hFE, 8'h01, 8'h40, 8'hE7, 8'hFF};
		probe_cx = '{5'd0, 5'd17, 5'd18, 5'd5, 5'd31};
		// sixteen bytes fill the queue, the last one is dropped
		foreach (opening[i])
			send_op(mqd_pkg::OP_PUSH, opening[i], 5'($urandom_range(31)));
		// decode before start runs on the reset registers
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd0);
		top_up_code();
		send_op(mqd_pkg::OP_START, 8'($urandom_range(255)), 5'($urandom_range(31)));
		foreach (probe_cx[i]) begin
			top_up_code();
			send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), probe_cx[i]);
		end
		send_op(mqd_pkg::OP_RESET, 8'hFF, 5'd31);
		top_up_code();
		send_op(mqd_pkg::OP_DECODE, 8'h00, 5'd18);
		top_up_code();
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd4);
	endtask

	task automatic test_random_decoding(input int n_items);
		int  first;
		int  done;
		int  pick;
		bit  calm_started;
		bit  drained;
		bit  held;
		logic [4:0] cx;
		first        = ops_sent;
		calm_started = 1'b0;
		drained      = 1'b0;
		held         = 1'b0;
		while (ops_sent - first < n_items) begin
			done = ops_sent - first;
			if (!calm_started && done >= n_items / 3) begin
				calm_started = 1'b1;
				no_gaps      = 1'b1;
			end
			if (no_gaps && done >= n_items / 3 + 80)
				no_gaps = 1'b0;
			if (!drained && done >= n_items / 2) begin
				drained = 1'b1;
				wait_for_decisions();
			end
			if (!held && done >= 2 * n_items / 3) begin
				held         = 1'b1;
				hold_request = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 68) begin
				// a few busy contexts walk deep into the probability table
				if ($urandom_range(19) == 0)
					cx = 5'($urandom_range(31, mqd_pkg::NUM_CONTEXTS));
				else if ($urandom_range(1) == 0)
					cx = 5'($urandom_range(3));
				else
					cx = 5'($urandom_range(mqd_pkg::NUM_CONTEXTS - 1));
				top_up_code();
				send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), cx);
			end else if (pick < 72) begin
				send_op(mqd_pkg::OP_RESET, 8'($urandom_range(255)),
					5'($urandom_range(31)));
			end else if (pick < 78) begin
				top_up_code();
				send_op(mqd_pkg::OP_START, 8'($urandom_range(255)),
					5'($urandom_range(31)));
			end else if (code_bytes.size() < mqd_pkg::BYTE_QUEUE_DEPTH) begin
				send_op(mqd_pkg::OP_PUSH, next_code_byte(), 5'($urandom_range(31)));
			end else begin
				send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)),
					5'($urandom_range(18)));
			end
		end
	endtask

	// the end flag is sticky until reset, so these cases come last
	task automatic test_end_of_data();
		int guard;
		if ($urandom_range(1) == 1) begin
			while (code_bytes.size() > mqd_pkg::BYTE_QUEUE_DEPTH - 2)
				send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd18);
			send_op(mqd_pkg::OP_PUSH, mqd_pkg::BYTE_STUFF, 5'($urandom_range(31)));
			send_op(mqd_pkg::OP_PUSH,
				8'($urandom_range(255, int'(mqd_pkg::MARKER_LIMIT) + 1)),
				5'($urandom_range(31)));
		end
		// otherwise the queue simply runs dry
		guard = 0;
		while (!mq_ended && guard < 300) begin
			send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd18);
			guard = guard + 1;
		end
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'($urandom_range(17)));
		send_op(mqd_pkg::OP_START, 8'($urandom_range(255)), 5'($urandom_range(31)));
		send_op(mqd_pkg::OP_START, 8'($urandom_range(255)), 5'($urandom_range(31)));
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd0);
		send_op(mqd_pkg::OP_PUSH, 8'($urandom_range(255)), 5'($urandom_range(31)));
		send_op(mqd_pkg::OP_START, 8'($urandom_range(255)), 5'($urandom_range(31)));
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd31);
		send_op(mqd_pkg::OP_DECODE, 8'($urandom_range(255)), 5'd3);
	endtask

	always @(posedge clk) begin
		decision_t want;
		if (rsp.valid && rsp.ready) begin
			if (pending_decisions.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= 10)
					$display("%0t: unexpected transaction: decision %b end_seen %b",
						$realtime, rsp.decision, rsp.end_seen);
			end else begin
				want = pending_decisions.pop_front();
				if (rsp.decision !== want.decision || rsp.end_seen !== want.end_seen) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= 10)
						$display("%0t: mismatch: expected decision %b end_seen %b, got %b %b",
							$realtime, want.decision, want.end_seen, rsp.decision,
							rsp.end_seen);
				end
			end
		end
	end

	// receiver: random stalls, a calm stretch and one long hold-off
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rsp.ready <= 1'b0;
				for (int i = 0; i < HOLD_CYCLES; i++)
					@(posedge clk);
			end else begin
				rsp.ready <= no_gaps || ($urandom_range(99) >= GAP_PERCENT);
				@(posedge clk);
			end
		end
	end

	initial begin
		req.valid         <= 1'b0;
		req.op            <= mqd_pkg::OP_PUSH;
		req.byte_value    <= '0;
		req.context_index <= '0;
		mismatch_count = 0;
		ops_sent       = 0;
		no_gaps        = 1'b0;
		hold_request   = 1'b0;
		mq_a           = mqd_pkg::INTERVAL_INIT;
		mq_c           = '0;
		mq_ct          = '0;
		mq_last_byte   = '0;
		mq_ended       = 1'b0;
		tail_byte      = '0;
		restore_contexts();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_decoding(300);
		test_end_of_data();

		wait_for_decisions();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_decisions.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/mqd_pkg.sv
hw/rtl/mqd_req_if.sv
hw/rtl/mqd_rsp_if.sv
hw/rtl/mq_arithmetic_decoder_core.sv
sim/tb_mq_arithmetic_decoder_core.sv
